// ----- hw/rtl/weighted_capped_rate_sharer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the weighted capped rate sharer
// Clocked, reset-qualified implication checks used by the datapath module.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_CAPPED_RATE_SHARER_ASSERT_SVH
`define WEIGHTED_CAPPED_RATE_SHARER_ASSERT_SVH

// Same-cycle implication.
`define WCRS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wcrs assertion failed");

// Next-cycle implication.
`define WCRS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wcrs assertion failed");

`endif

// ----- hw/rtl/wcrs_pkg.sv -----
// ----------------------------------------------------------------------------
// wcrs_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package wcrs_pkg;

	localparam int MAX_FLOWS_DEF = 16;
	localparam int REQ_W  = 2;
	localparam int SLOT_W = 4;
	localparam int RATE_W = 32;
	localparam int PRIO_W = 8;
	localparam int SUM_W  = 36;
	localparam int STAT_W = 2;
	localparam int PROD_W = SUM_W + PRIO_W;
	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 40;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	localparam logic [REQ_W-1:0] REQ_REG   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_UPD   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DEREG = 2'd2;
	localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [RATE_W-1:0] cap;
		logic [RATE_W-1:0] alloc;
	} entry_t;

	typedef struct packed {
		logic load;
		logic do_reg;
		logic emit_bad;
		logic do_dereg;
		logic rd_slot;
		logic upd_sum;
		logic rd_idx;
		logic init_slot;
		logic pass_start;
		logic mul;
		logic skip;
		logic div_start;
		logic apply;
		logic pass_inc;
		logic out_start;
		logic emit_alloc;
		logic store_total;
	} cmd_t;

	typedef struct packed {
		logic req_none;
		logic req_reg;
		logic req_dereg;
		logic in_use;
		logic idx_last;
		logic cont;
		logic elig;
		logic div_done;
		logic any;
		logic out_free;
		logic idx_valid;
	} sts_t;

endpackage

// ----- hw/rtl/wcrs_ram.sv -----
// ----------------------------------------------------------------------------
// wcrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wcrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata_q
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end
endmodule

// ----- hw/rtl/wcrs_div.sv -----
// ----------------------------------------------------------------------------
// wcrs_div
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wcrs_div #(
	parameter int NUM_W = 44,
	parameter int DEN_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;

	assign rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, den} : rem_sh;
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ----- hw/rtl/wcrs_datapath.sv -----
// ----------------------------------------------------------------------------
// wcrs_datapath
// Flow table, rate sums, sharing arithmetic and the output register.
// ----------------------------------------------------------------------------
`include "weighted_capped_rate_sharer_assert.svh"

module wcrs_datapath #(
	parameter int MAX_FLOWS = wcrs_pkg::MAX_FLOWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wcrs_pkg::cmd_t                  cmd,
	output wcrs_pkg::sts_t                  sts,
	input  logic [wcrs_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [wcrs_pkg::REQ_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [wcrs_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic [wcrs_pkg::STAT_W-1:0]     m_tuser,
	output logic                            m_tlast
);
	localparam int IDX_W  = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
	localparam int LOG_N  = $clog2(MAX_FLOWS) + 1;
	localparam int PSUM_W = wcrs_pkg::PRIO_W + LOG_N;
	localparam int AGG_W  = wcrs_pkg::SUM_W + LOG_N;
	localparam int PASS_W = $clog2(MAX_FLOWS + 2);
	localparam int RW     = wcrs_pkg::RATE_W;
	localparam int SW     = wcrs_pkg::SUM_W;
	localparam int EW     = $bits(wcrs_pkg::entry_t);

	logic [wcrs_pkg::REQ_W-1:0]  req_q;
	logic [wcrs_pkg::SLOT_W-1:0] slot_q;
	logic [RW-1:0]               rate_q;
	logic [wcrs_pkg::PRIO_W-1:0] prio_q;
	logic [RW-1:0]               cap_q;

	logic [MAX_FLOWS-1:0] valid_q;
	logic [MAX_FLOWS-1:0] capped_q;
	logic [SW-1:0]        rate_sum_q;
	logic [SW-1:0]        left_q;
	logic [AGG_W-1:0]     agg_q;
	logic [AGG_W-1:0]     total_q;
	logic [PSUM_W-1:0]    psum_q;
	logic [PASS_W-1:0]    pass_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 any_q;
	logic [wcrs_pkg::PROD_W-1:0] prod_q;

	logic                          out_valid_q;
	logic [wcrs_pkg::STAT_W-1:0]   out_stat_q;
	logic [wcrs_pkg::SLOT_W-1:0]   out_slot_q;
	logic [RW-1:0]                 out_bps_q;
	logic                          out_last_q;

	wcrs_pkg::entry_t rd_ent;
	wcrs_pkg::entry_t wr_ent;
	logic [EW-1:0]    rdata;
	logic             ram_we;
	logic             ram_re;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_raddr;

	logic [IDX_W-1:0] slot_idx;
	logic             free_found;
	logic [IDX_W-1:0] free_idx;
	logic [IDX_W-1:0] hi_idx;
	logic             in_use;
	logic             div_done;
	logic [wcrs_pkg::PROD_W-1:0] quo;
	logic [wcrs_pkg::PROD_W-1:0] r_val;
	logic             hit;
	logic [SW:0]      reg_sum;
	logic [SW:0]      upd_t;
	logic [SW:0]      upd_t2;
	logic [SW-1:0]    upd_sum;
	logic             emit_reg;

	assign rd_ent   = wcrs_pkg::entry_t'(rdata);
	assign slot_idx = IDX_W'(slot_q);
	assign in_use   = (32'(slot_q) < 32'(MAX_FLOWS)) && valid_q[slot_idx];

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		hi_idx     = '0;
		for (int i = MAX_FLOWS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
		for (int i = 0; i < MAX_FLOWS; i++) begin
			if (valid_q[i]) begin
				hi_idx = IDX_W'(i);
			end
		end
	end

	assign reg_sum = {1'b0, rate_sum_q} + (SW + 1)'(rate_q);
	assign upd_t   = reg_sum;
	assign upd_t2  = (upd_t >= (SW + 1)'(rd_ent.alloc)) ? upd_t - (SW + 1)'(rd_ent.alloc) : '0;
	assign upd_sum = upd_t2[SW] ? wcrs_pkg::SUM_MAX : upd_t2[SW-1:0];

	assign r_val = (psum_q == '0) ? '0 : quo;
	assign hit   = r_val >= wcrs_pkg::PROD_W'(rd_ent.cap);

	assign emit_reg = cmd.do_reg && free_found;

	always_comb begin
		wr_ent = rd_ent;
		if (cmd.do_reg) begin
			wr_ent.prio  = prio_q;
			wr_ent.cap   = cap_q;
			wr_ent.alloc = rate_q;
		end else if (cmd.init_slot) begin
			wr_ent.alloc = '0;
		end else if (hit) begin
			wr_ent.alloc = rd_ent.cap;
		end else begin
			wr_ent.alloc = r_val[RW-1:0];
		end
	end

	assign ram_we    = emit_reg || (cmd.init_slot && valid_q[idx_q]) || cmd.apply;
	assign ram_waddr = cmd.do_reg ? free_idx : idx_q;
	assign ram_re    = cmd.rd_slot || cmd.rd_idx;
	assign ram_raddr = cmd.rd_slot ? slot_idx : idx_q;

	wcrs_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_FLOWS)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (EW'(wr_ent)),
		.re     (ram_re),
		.raddr  (ram_raddr),
		.rdata_q(rdata)
	);

	wcrs_div #(
		.NUM_W(wcrs_pkg::PROD_W),
		.DEN_W(PSUM_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (prod_q),
		.den   (psum_q),
		.done  (div_done),
		.quo   (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= s_tuser;
			slot_q <= s_tdata[3:0];
			rate_q <= s_tdata[35:4];
			prio_q <= s_tdata[43:36];
			cap_q  <= s_tdata[75:44];
		end
		if (cmd.mul) begin
			prod_q <= wcrs_pkg::PROD_W'(left_q) * wcrs_pkg::PROD_W'(rd_ent.prio);
		end
		if (cmd.do_reg) begin
			out_stat_q <= free_found ? wcrs_pkg::ST_OK : wcrs_pkg::ST_FULL;
			out_slot_q <= free_found ? wcrs_pkg::SLOT_W'(free_idx) : '0;
			out_bps_q  <= free_found ? rate_q : '0;
			out_last_q <= 1'b1;
		end else if (cmd.emit_bad) begin
			out_stat_q <= wcrs_pkg::ST_BAD;
			out_slot_q <= slot_q;
			out_bps_q  <= '0;
			out_last_q <= 1'b1;
		end else if (cmd.do_dereg) begin
			out_stat_q <= wcrs_pkg::ST_OK;
			out_slot_q <= slot_q;
			out_bps_q  <= '0;
			out_last_q <= 1'b1;
		end else if (cmd.emit_alloc) begin
			out_stat_q <= wcrs_pkg::ST_OK;
			out_slot_q <= wcrs_pkg::SLOT_W'(idx_q);
			out_bps_q  <= rd_ent.alloc;
			out_last_q <= idx_q == hi_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			capped_q    <= '0;
			rate_sum_q  <= '0;
			left_q      <= '0;
			agg_q       <= '0;
			total_q     <= '0;
			psum_q      <= '0;
			pass_q      <= '0;
			idx_q       <= '0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.do_reg || cmd.emit_bad || cmd.do_dereg || cmd.emit_alloc) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_reg) begin
				valid_q[free_idx] <= 1'b1;
				rate_sum_q <= reg_sum[SW] ? wcrs_pkg::SUM_MAX : reg_sum[SW-1:0];
			end
			if (cmd.do_dereg) begin
				valid_q[slot_idx] <= 1'b0;
			end
			if (cmd.upd_sum) begin
				rate_sum_q <= upd_sum;
				left_q     <= upd_sum;
				agg_q      <= '0;
				psum_q     <= '0;
				pass_q     <= '0;
				idx_q      <= '0;
				capped_q   <= '0;
			end
			if (cmd.init_slot) begin
				if (valid_q[idx_q]) begin
					psum_q <= psum_q + PSUM_W'(rd_ent.prio);
				end
				idx_q <= IDX_W'(idx_q + 1'b1);
			end
			if (cmd.pass_start) begin
				agg_q <= '0;
				any_q <= 1'b0;
				idx_q <= '0;
			end
			if (cmd.skip) begin
				idx_q <= IDX_W'(idx_q + 1'b1);
			end
			if (cmd.apply) begin
				idx_q <= IDX_W'(idx_q + 1'b1);
				if (hit) begin
					left_q           <= left_q - SW'(rd_ent.cap);
					psum_q           <= psum_q - PSUM_W'(rd_ent.prio);
					capped_q[idx_q]  <= 1'b1;
					any_q            <= 1'b1;
				end else begin
					agg_q <= agg_q + AGG_W'(r_val[RW-1:0]);
				end
			end
			if (cmd.pass_inc) begin
				pass_q <= pass_q + 1'b1;
			end
			if (cmd.out_start) begin
				idx_q   <= '0;
				total_q <= '0;
			end
			if (cmd.emit_alloc) begin
				idx_q   <= IDX_W'(idx_q + 1'b1);
				total_q <= total_q + AGG_W'(rd_ent.alloc);
			end
			if (cmd.store_total) begin
				rate_sum_q <= (total_q > AGG_W'(wcrs_pkg::SUM_MAX)) ?
					wcrs_pkg::SUM_MAX : SW'(total_q);
			end
		end
	end

	always_comb begin
		sts           = '0;
		sts.req_none  = req_q == wcrs_pkg::REQ_NONE;
		sts.req_reg   = req_q == wcrs_pkg::REQ_REG;
		sts.req_dereg = req_q == wcrs_pkg::REQ_DEREG;
		sts.in_use    = in_use;
		sts.idx_last  = idx_q == IDX_W'(MAX_FLOWS - 1);
		sts.cont      = (32'(pass_q) <= 32'(MAX_FLOWS)) &&
			(AGG_W'(left_q) > agg_q + 1'b1) && (psum_q != '0);
		sts.elig      = valid_q[idx_q] && !capped_q[idx_q] && (rd_ent.alloc < rd_ent.cap);
		sts.div_done  = div_done;
		sts.any       = any_q;
		sts.out_free  = !out_valid_q || m_tready;
		sts.idx_valid = valid_q[idx_q];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_bps_q, out_slot_q};
	assign m_tuser  = out_stat_q;
	assign m_tlast  = out_last_q;

	`WCRS_ASSERT_IMP(a_emit_free, clk, arst_n, cmd.emit_alloc, !out_valid_q || m_tready)
	`WCRS_ASSERT_IMP(a_pass_psum, clk, arst_n, cmd.pass_start, psum_q != '0)
	`WCRS_ASSERT_NXT(a_cap_left, clk, arst_n, cmd.apply && hit,
		left_q == $past(left_q) - SW'($past(rd_ent.cap)))
endmodule

// ----- hw/rtl/wcrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// wcrs_ctrl
// Sequencer for request decode, sharing passes and result delivery.
// ----------------------------------------------------------------------------
module wcrs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  wcrs_pkg::sts_t sts,
	output wcrs_pkg::cmd_t cmd
);
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DEC      = 4'd1;
	localparam logic [3:0] S_UPD      = 4'd2;
	localparam logic [3:0] S_INIT_RD  = 4'd3;
	localparam logic [3:0] S_INIT_WR  = 4'd4;
	localparam logic [3:0] S_PASS_CHK = 4'd5;
	localparam logic [3:0] S_RD       = 4'd6;
	localparam logic [3:0] S_EVAL     = 4'd7;
	localparam logic [3:0] S_DIV_GO   = 4'd8;
	localparam logic [3:0] S_DIV_WAIT = 4'd9;
	localparam logic [3:0] S_PASS_END = 4'd10;
	localparam logic [3:0] S_OUT_RD   = 4'd11;
	localparam logic [3:0] S_OUT_EM   = 4'd12;
	localparam logic [3:0] S_FIN      = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign s_tready = (state_q == S_IDLE) && sts.out_free;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid && s_tready) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_IDLE;
				if (sts.req_reg) begin
					cmd.do_reg = 1'b1;
				end else if (sts.req_none) begin
					state_d = S_IDLE;
				end else if (!sts.in_use) begin
					cmd.emit_bad = 1'b1;
				end else if (sts.req_dereg) begin
					cmd.do_dereg = 1'b1;
				end else begin
					cmd.rd_slot = 1'b1;
					state_d     = S_UPD;
				end
			end
			S_UPD: begin
				cmd.upd_sum = 1'b1;
				state_d     = S_INIT_RD;
			end
			S_INIT_RD: begin
				cmd.rd_idx = 1'b1;
				state_d    = S_INIT_WR;
			end
			S_INIT_WR: begin
				cmd.init_slot = 1'b1;
				state_d       = sts.idx_last ? S_PASS_CHK : S_INIT_RD;
			end
			S_PASS_CHK: begin
				if (sts.cont) begin
					cmd.pass_start = 1'b1;
					state_d        = S_RD;
				end else begin
					cmd.out_start = 1'b1;
					state_d       = S_OUT_RD;
				end
			end
			S_RD: begin
				cmd.rd_idx = 1'b1;
				state_d    = S_EVAL;
			end
			S_EVAL: begin
				if (sts.elig) begin
					cmd.mul = 1'b1;
					state_d = S_DIV_GO;
				end else begin
					cmd.skip = 1'b1;
					state_d  = sts.idx_last ? S_PASS_END : S_RD;
				end
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.apply = 1'b1;
					state_d   = sts.idx_last ? S_PASS_END : S_RD;
				end
			end
			S_PASS_END: begin
				if (sts.any) begin
					cmd.pass_inc = 1'b1;
					state_d      = S_PASS_CHK;
				end else begin
					cmd.out_start = 1'b1;
					state_d       = S_OUT_RD;
				end
			end
			S_OUT_RD: begin
				cmd.rd_idx = 1'b1;
				state_d    = S_OUT_EM;
			end
			S_OUT_EM: begin
				if (!sts.idx_valid) begin
					cmd.skip = 1'b1;
					state_d  = sts.idx_last ? S_FIN : S_OUT_RD;
				end else if (sts.out_free) begin
					cmd.emit_alloc = 1'b1;
					state_d        = sts.idx_last ? S_FIN : S_OUT_RD;
				end
			end
			S_FIN: begin
				cmd.store_total = 1'b1;
				state_d         = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ----- hw/rtl/weighted_capped_rate_sharer.sv -----
// ----------------------------------------------------------------------------
// weighted_capped_rate_sharer
// Flow table that shares a rate budget by priority weight under per-flow caps.
// ----------------------------------------------------------------------------
// One request word is handled at a time. Register, deregister and rejected
// requests each return one result word. An update walks the table to clear
// allocations, then runs up to MAX_FLOWS + 1 sharing passes; in each pass the
// serial divider forms the weighted share of every flow that is offered one,
// one quotient bit per cycle. Results follow, one word per valid flow in
// ascending slot order, with tlast on the highest valid slot.
module weighted_capped_rate_sharer #(
	parameter int MAX_FLOWS = wcrs_pkg::MAX_FLOWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// flow_slot, rate_bps, flow_priority, cap_bps, zero pad
	input  logic [wcrs_pkg::S_TDATA_W-1:0]  s_tdata,
	// req_type
	input  logic [wcrs_pkg::REQ_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_slot, allocated_bps, zero pad
	output logic [wcrs_pkg::M_TDATA_W-1:0]  m_tdata,
	// status
	output logic [wcrs_pkg::STAT_W-1:0]     m_tuser,
	output logic                            m_tlast
);
	wcrs_pkg::cmd_t cmd;
	wcrs_pkg::sts_t sts;

	wcrs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	wcrs_datapath #(
		.MAX_FLOWS(MAX_FLOWS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);
endmodule
